>>> src/battery_charge_sequencer_unit_defines.svh
// Assertion macros shared by the checker of the battery charge sequencer.
`ifndef BATTERY_CHARGE_SEQUENCER_UNIT_DEFINES_SVH
`define BATTERY_CHARGE_SEQUENCER_UNIT_DEFINES_SVH

// Same-cycle implication, disabled while reset is asserted.
`define BCS_ASSERT_IMPLY(lbl, clk, rstn, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |-> (cons)) \
        else $error("battery charge sequencer check failed");

// Next-cycle implication, disabled while reset is asserted.
`define BCS_ASSERT_NEXT(lbl, clk, rstn, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) \
        else $error("battery charge sequencer check failed");

`endif

>>> src/bcs_pkg.sv
`timescale 1ns / 1ps

package bcs_pkg;

    // Number of battery ranges that take part in the match.
    localparam int TABLE_ENTRIES = 3;

    // Charger states.
    localparam logic [2:0] ST_IDLE = 3'd0;
    localparam logic [2:0] ST_DET  = 3'd1;
    localparam logic [2:0] ST_CFG  = 3'd2;
    localparam logic [2:0] ST_CHG  = 3'd3;
    localparam logic [2:0] ST_FIN  = 3'd4;
    localparam logic [2:0] ST_FLT  = 3'd5;

    // LED codes.
    localparam logic [2:0] LED_STANDBY = 3'd0;
    localparam logic [2:0] LED_CHG     = 3'd1;
    localparam logic [2:0] LED_CHARGED = 3'd2;
    localparam logic [2:0] LED_FLT     = 3'd3;
    localparam logic [2:0] LED_KEEP    = 3'd4;

    // Buzzer commands.
    localparam logic [1:0] BUZ_KEEP = 2'd0;
    localparam logic [1:0] BUZ_ON   = 2'd1;
    localparam logic [1:0] BUZ_OFF  = 2'd2;

    // Charger commands.
    localparam logic [1:0] CCMD_NONE   = 2'd0;
    localparam logic [1:0] CCMD_SETPT  = 2'd1;
    localparam logic [1:0] CCMD_PWR_ON = 2'd2;
    localparam logic [1:0] CCMD_PWR_OFF = 2'd3;

    // Word kinds carried in tuser.
    localparam logic KIND_POLL    = 1'b0;
    localparam logic KIND_OUTCOME = 1'b1;

    // Matched-entry code for no battery.
    localparam logic [1:0] NO_ENTRY = 2'd3;

    // Reset value of the insertion threshold in decivolts.
    localparam logic [15:0] INSERT_THRESHOLD_RESET = 16'd100;

    // Battery table: low bound inclusive, high bound exclusive, set-points.
    // The last row stands for no entry and gives zero set-points.
    localparam logic [15:0] TAB_LO [4] = '{16'd100, 16'd550, 16'd680, 16'd0};
    localparam logic [15:0] TAB_HI [4] = '{16'd550, 16'd680, 16'd850, 16'd0};
    localparam logic [9:0]  TAB_V  [4] = '{10'd584, 10'd730, 10'd876, 10'd0};
    localparam logic [7:0]  TAB_I  [4] = '{8'd60, 8'd60, 8'd80, 8'd0};

    // One input word.
    typedef struct packed {
        logic        cmd;
        logic        link_ok;
        logic        link_offline;
        logic [15:0] batt_dv;
        logic        charger_fault;
        logic        charger_full;
        logic        write_ok;
    } item_t;

    // One result word.
    typedef struct packed {
        logic [1:0] battery_kind;
        logic [7:0] target_current_da;
        logic [9:0] target_volt_dv;
        logic [1:0] charger_cmd;
        logic [1:0] buzzer_cmd;
        logic [2:0] led_code;
        logic [2:0] charge_state;
    } result_t;

    // Sequencer state handed between the state registers and the step logic.
    typedef struct packed {
        logic [2:0] state;
        logic [1:0] entry;
    } seq_state_t;

endpackage

>>> src/bcs_step_logic.sv
`timescale 1ns / 1ps

module bcs_step_logic (
    input  bcs_pkg::item_t      item,
    input  bcs_pkg::seq_state_t cur,
    input  logic [15:0]         threshold,
    output bcs_pkg::seq_state_t nxt,
    output bcs_pkg::result_t    result
);
    import bcs_pkg::*;

    logic       found;
    logic [1:0] hit_idx;
    logic       present;
    logic [2:0] led;
    logic [1:0] buz;
    logic [1:0] ccmd;

    // Range search over the battery table, first hit wins.
    always_comb
    begin
        found   = 1'b0;
        hit_idx = NO_ENTRY;
        for (int k = 0; k < TABLE_ENTRIES; k++)
        begin
            if (!found && item.batt_dv >= TAB_LO[k] && item.batt_dv < TAB_HI[k])
            begin
                found   = 1'b1;
                hit_idx = 2'(k);
            end
        end
    end

    assign present = (item.batt_dv >= threshold);

    // State transition and actuator commands for one word.
    always_comb
    begin
        nxt  = cur;
        led  = LED_KEEP;
        buz  = BUZ_KEEP;
        ccmd = CCMD_NONE;
        if (item.cmd == KIND_OUTCOME)
        begin
            if (item.write_ok)
            begin
                if (cur.state == ST_DET)
                begin
                    nxt.state = ST_CFG;
                end
                else if (cur.state == ST_CFG)
                begin
                    nxt.state = ST_CHG;
                end
            end
        end
        else if (!item.link_ok)
        begin
            led = LED_FLT;
            if (item.link_offline)
            begin
                nxt.state = ST_FLT;
                buz       = BUZ_ON;
            end
        end
        else if (item.charger_fault)
        begin
            ccmd      = CCMD_PWR_OFF;
            nxt.state = ST_FLT;
            led       = LED_FLT;
            buz       = BUZ_ON;
        end
        else
        begin
            case (cur.state)
                ST_IDLE:
                begin
                    led = LED_STANDBY;
                    if (present && found)
                    begin
                        nxt.entry = hit_idx;
                        nxt.state = ST_DET;
                    end
                end
                ST_DET:
                begin
                    ccmd = CCMD_SETPT;
                end
                ST_CFG:
                begin
                    ccmd = CCMD_PWR_ON;
                end
                ST_CHG:
                begin
                    led = LED_CHG;
                    if (item.charger_full)
                    begin
                        ccmd      = CCMD_PWR_OFF;
                        nxt.state = ST_FIN;
                    end
                end
                ST_FIN:
                begin
                    led = LED_CHARGED;
                    if (!present)
                    begin
                        nxt.state = ST_IDLE;
                        nxt.entry = NO_ENTRY;
                    end
                end
                default:
                begin
                    if (!present)
                    begin
                        buz       = BUZ_OFF;
                        nxt.state = ST_IDLE;
                        nxt.entry = NO_ENTRY;
                    end
                end
            endcase
        end
    end

    // Result word with the set-points of the entry after this word.
    always_comb
    begin
        result.charge_state      = nxt.state;
        result.led_code          = led;
        result.buzzer_cmd        = buz;
        result.charger_cmd       = ccmd;
        result.target_volt_dv    = TAB_V[nxt.entry];
        result.target_current_da = TAB_I[nxt.entry];
        result.battery_kind      = nxt.entry;
    end

endmodule

>>> src/battery_charge_sequencer_unit.sv
`timescale 1ns / 1ps

// Battery charge sequencer. Each input word (a poll report or a charger write
// outcome) yields exactly one result word with the new charger state, LED,
// buzzer and charger command and the set-points of the matched battery. A word
// passes an input register, one level of decision logic and a result register,
// and its result word shows tvalid once it reaches the result register. One
// word per cycle is taken as long as the result side keeps tready high; the rate
// is set by the state register, updated in the cycle a word moves to the result
// register. The user must write the insertion threshold through cfg_we/cfg_wdata
// only while no word is in flight; the block itself does not enforce this.
module battery_charge_sequencer_unit (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    // link_ok, link_offline, battery voltage[15:0], charger_fault, charger_full,
    // write_ok, zero fill
    input  logic [23:0] s_axis_tdata,
    // cmd
    input  logic [0:0]  s_axis_tuser,
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    // charge_state[2:0], led_code[2:0], buzzer_cmd[1:0], charger_cmd[1:0],
    // target voltage[9:0], target_current_da[7:0], battery_kind[1:0],
    // zero fill
    output logic [31:0] m_axis_tdata,
    input  logic        cfg_we,
    input  logic [15:0] cfg_wdata
);
    import bcs_pkg::*;

    logic       in_valid_reg;
    logic       in_valid_next;
    item_t      in_item_reg;
    item_t      in_item_next;
    logic       out_valid_reg;
    logic       out_valid_next;
    result_t    out_word_reg;
    result_t    out_word_next;
    seq_state_t seq_reg;
    seq_state_t seq_next;
    logic [15:0] threshold_reg;
    logic [15:0] threshold_next;
    item_t      s_item;
    seq_state_t step_nxt;
    result_t    step_result;
    logic       move;

    // Unpack the incoming word.
    assign s_item.cmd           = s_axis_tuser[0];
    assign s_item.link_ok       = s_axis_tdata[0];
    assign s_item.link_offline  = s_axis_tdata[1];
    assign s_item.batt_dv       = s_axis_tdata[17:2];
    assign s_item.charger_fault = s_axis_tdata[18];
    assign s_item.charger_full  = s_axis_tdata[19];
    assign s_item.write_ok      = s_axis_tdata[20];

    // A word moves on when the result register is free or being emptied.
    assign move          = in_valid_reg && (!out_valid_reg || m_axis_tready);
    assign s_axis_tready = !in_valid_reg || move;

    bcs_step_logic u_step (
        .item      (in_item_reg),
        .cur       (seq_reg),
        .threshold (threshold_reg),
        .nxt       (step_nxt),
        .result    (step_result)
    );

    // Next values of the pipeline, state and configuration registers.
    always_comb
    begin
        in_valid_next  = in_valid_reg;
        in_item_next   = in_item_reg;
        out_valid_next = out_valid_reg;
        out_word_next  = out_word_reg;
        seq_next       = seq_reg;
        threshold_next = threshold_reg;
        if (out_valid_reg && m_axis_tready)
        begin
            out_valid_next = 1'b0;
        end
        if (move)
        begin
            in_valid_next  = 1'b0;
            out_valid_next = 1'b1;
            out_word_next  = step_result;
            seq_next       = step_nxt;
        end
        if (s_axis_tvalid && s_axis_tready)
        begin
            in_valid_next = 1'b1;
            in_item_next  = s_item;
        end
        if (cfg_we)
        begin
            threshold_next = cfg_wdata;
        end
    end

    // Control and state registers.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
            seq_reg.state <= ST_IDLE;
            seq_reg.entry <= NO_ENTRY;
            threshold_reg <= INSERT_THRESHOLD_RESET;
        end
        else
        begin
            in_valid_reg  <= in_valid_next;
            out_valid_reg <= out_valid_next;
            seq_reg       <= seq_next;
            threshold_reg <= threshold_next;
        end
    end

    // Payload registers.
    always_ff @(posedge clk)
    begin
        in_item_reg  <= in_item_next;
        out_word_reg <= out_word_next;
    end

    assign m_axis_tvalid = out_valid_reg;
    assign m_axis_tdata  = {2'b00, out_word_reg};

endmodule

>>> src/bcs_checker.sv
`timescale 1ns / 1ps
`include "battery_charge_sequencer_unit_defines.svh"

module bcs_checker (
    input logic        clk,
    input logic        rst_n,
    input logic        m_axis_tvalid,
    input logic        m_axis_tready,
    input logic [31:0] m_axis_tdata
);
    import bcs_pkg::*;

    logic [2:0] st;
    logic [1:0] buz;
    logic [1:0] ccmd;
    logic [9:0] tv;
    logic [7:0] ti;
    logic [1:0] kind;

    assign st   = m_axis_tdata[2:0];
    assign buz  = m_axis_tdata[7:6];
    assign ccmd = m_axis_tdata[9:8];
    assign tv   = m_axis_tdata[19:10];
    assign ti   = m_axis_tdata[27:20];
    assign kind = m_axis_tdata[29:28];

    // A stalled result word stays put.
    `BCS_ASSERT_NEXT(a_out_hold, clk, rst_n, m_axis_tvalid && !m_axis_tready, m_axis_tvalid && $stable(m_axis_tdata))

    // No matched battery means zero set-points.
    `BCS_ASSERT_IMPLY(a_no_entry_zero, clk, rst_n, m_axis_tvalid && kind == NO_ENTRY, tv == 10'd0 && ti == 8'd0)

    // Power on is only requested from the configured state.
    `BCS_ASSERT_IMPLY(a_pwr_on_cfg, clk, rst_n, m_axis_tvalid && ccmd == CCMD_PWR_ON, st == ST_CFG)

    // Power off leads to either finished or fault.
    `BCS_ASSERT_IMPLY(a_pwr_off_state, clk, rst_n, m_axis_tvalid && ccmd == CCMD_PWR_OFF, st == ST_FIN || st == ST_FLT)

    // Silencing the buzzer only happens on the way back to idle.
    `BCS_ASSERT_IMPLY(a_buz_off_idle, clk, rst_n, m_axis_tvalid && buz == BUZ_OFF, st == ST_IDLE && kind == NO_ENTRY)

endmodule

bind battery_charge_sequencer_unit bcs_checker u_bcs_checker (
    .clk           (clk),
    .rst_n         (rst_n),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata)
);

>>> sim/tb_top.sv
`timescale 1ns / 1ps

module tb_top;

    import bcs_pkg::*;

    // Predicts the charger sequencer result for every accepted word and checks
    // the result words against the oldest pending prediction.
    class charge_scoreboard;
        logic [2:0]  state;
        logic [1:0]  entry;
        logic [15:0] threshold;
        result_t     expected_q[$];
        int          words_in;
        int          words_out;
        int          mismatches;
        logic [5:0]  states_seen;

        function new();
            state       = ST_IDLE;
            entry       = NO_ENTRY;
            threshold   = INSERT_THRESHOLD_RESET;
            words_in    = 0;
            words_out   = 0;
            mismatches  = 0;
            states_seen = 6'b000001;
        endfunction

        function void set_threshold(logic [15:0] value);
            threshold = value;
        endfunction

        function int pending();
            return expected_q.size();
        endfunction

        // Table row whose voltage range holds v, or no entry.
        function logic [1:0] battery_match(logic [15:0] v);
            for (int k = 0; k < TABLE_ENTRIES; k++)
            begin
                if (v >= TAB_LO[k] && v < TAB_HI[k])
                    return k[1:0];
            end
            return NO_ENTRY;
        endfunction

        // Advances the predicted state by one accepted word and queues its result.
        function void note_input(item_t it);
            result_t    r;
            logic [1:0] hit;
            r = '0;
            r.led_code = LED_KEEP;
            r.buzzer_cmd = BUZ_KEEP;
            r.charger_cmd = CCMD_NONE;
            words_in++;
            if (it.cmd == KIND_OUTCOME)
            begin
                if (it.write_ok)
                begin
                    if (state == ST_DET)
                        state = ST_CFG;
                    else if (state == ST_CFG)
                        state = ST_CHG;
                end
            end
            else if (!it.link_ok)
            begin
                r.led_code = LED_FLT;
                if (it.link_offline)
                begin
                    state = ST_FLT;
                    r.buzzer_cmd = BUZ_ON;
                end
            end
            else if (it.charger_fault)
            begin
                r.charger_cmd = CCMD_PWR_OFF;
                r.led_code = LED_FLT;
                r.buzzer_cmd = BUZ_ON;
                state = ST_FLT;
            end
            else
            begin
                case (state)
                    ST_IDLE:
                    begin
                        r.led_code = LED_STANDBY;
                        hit = battery_match(it.batt_dv);
                        if (it.batt_dv >= threshold && hit != NO_ENTRY)
                        begin
                            entry = hit;
                            state = ST_DET;
                        end
                    end
                    ST_DET: r.charger_cmd = CCMD_SETPT;
                    ST_CFG: r.charger_cmd = CCMD_PWR_ON;
                    ST_CHG:
                    begin
                        r.led_code = LED_CHG;
                        if (it.charger_full)
                        begin
                            r.charger_cmd = CCMD_PWR_OFF;
                            state = ST_FIN;
                        end
                    end
                    ST_FIN:
                    begin
                        r.led_code = LED_CHARGED;
                        if (it.batt_dv < threshold)
                        begin
                            state = ST_IDLE;
                            entry = NO_ENTRY;
                        end
                    end
                    default:
                    begin
                        // Fault clears once the battery has been removed.
                        if (it.batt_dv < threshold)
                        begin
                            r.buzzer_cmd = BUZ_OFF;
                            state = ST_IDLE;
                            entry = NO_ENTRY;
                        end
                    end
                endcase
            end
            states_seen[state] = 1'b1;
            r.charge_state = state;
            r.battery_kind = entry;
            if (entry < TABLE_ENTRIES)
            begin
                r.target_volt_dv = TAB_V[entry];
                r.target_current_da = TAB_I[entry];
            end
            expected_q.push_back(r);
        endfunction

        function void note_error(string text);
            mismatches++;
            if (mismatches <= 10)
                $display("ERROR at %0t: %s", $realtime, text);
        endfunction

        function void check_result(result_t got);
            result_t want;
            words_out++;
            if (expected_q.size() == 0)
            begin
                note_error($sformatf("result word %h arrived with none pending", got));
                return;
            end
            want = expected_q.pop_front();
            if (got.charge_state !== want.charge_state || got.led_code !== want.led_code ||
                got.buzzer_cmd !== want.buzzer_cmd || got.charger_cmd !== want.charger_cmd ||
                got.target_volt_dv !== want.target_volt_dv ||
                got.target_current_da !== want.target_current_da ||
                got.battery_kind !== want.battery_kind)
                note_error($sformatf({"word %0d: state/led/buz/cmd/v/i/kind expected ",
                    "%0d/%0d/%0d/%0d/%0d/%0d/%0d, got %0d/%0d/%0d/%0d/%0d/%0d/%0d"},
                    words_out, want.charge_state, want.led_code, want.buzzer_cmd,
                    want.charger_cmd, want.target_volt_dv, want.target_current_da,
                    want.battery_kind, got.charge_state, got.led_code, got.buzzer_cmd,
                    got.charger_cmd, got.target_volt_dv, got.target_current_da,
                    got.battery_kind));
        endfunction
    endclass

    logic        clk;
    logic        rst_n;
    logic        s_axis_tvalid;
    logic        s_axis_tready;
    logic [23:0] s_axis_tdata;
    logic [0:0]  s_axis_tuser;
    logic        m_axis_tvalid;
    logic        m_axis_tready;
    logic [31:0] m_axis_tdata;
    logic        cfg_we;
    logic [15:0] cfg_wdata;

    charge_scoreboard sb;
    int               src_idle_pct;
    int               snk_stall_pct;

    battery_charge_sequencer_unit u_top (
        .clk           (clk),
        .rst_n         (rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .cfg_we        (cfg_we),
        .cfg_wdata     (cfg_wdata)
    );

    // Clock generation.
    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    // Run limit, several times the slowest legal run.
    initial
    begin
        #5_000_000;
        $display("Mismatches found");
        $finish;
    end

    // Result side: random stalls and checking of every accepted result word.
    always @(posedge clk)
    begin
        if (rst_n && m_axis_tvalid && m_axis_tready)
            sb.check_result(result_t'(m_axis_tdata[29:0]));
        m_axis_tready <= ($urandom_range(0, 99) >= snk_stall_pct);
    end

    // Presents one word, with a random gap ahead of it, and waits for acceptance.
    task automatic send_word(input item_t it);
        if ($urandom_range(0, 99) < src_idle_pct)
        begin
            s_axis_tvalid <= 1'b0;
            do
                @(posedge clk);
            while ($urandom_range(0, 99) < src_idle_pct);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tuser  <= it.cmd;
        s_axis_tdata  <= {3'b000, it.write_ok, it.charger_full, it.charger_fault,
                          it.batt_dv, it.link_offline, it.link_ok};
        @(posedge clk);
        while (!s_axis_tready)
            @(posedge clk);
        sb.note_input(it);
    endtask

    task automatic poll(input logic ok, input logic offline, input logic [15:0] v,
                        input logic fault, input logic full);
        item_t it;
        it = '0;
        it.cmd = KIND_POLL;
        it.link_ok = ok;
        it.link_offline = offline;
        it.batt_dv = v;
        it.charger_fault = fault;
        it.charger_full = full;
        send_word(it);
    endtask

    task automatic outcome(input logic ok);
        item_t it;
        it = '0;
        it.cmd = KIND_OUTCOME;
        it.write_ok = ok;
        send_word(it);
    endtask

    // Stops the input and waits until every pending result has been taken.
    task automatic drain();
        s_axis_tvalid <= 1'b0;
        @(posedge clk);
        while (sb.pending() != 0)
            @(posedge clk);
        repeat (4) @(posedge clk);
    endtask

    task automatic write_threshold(input logic [15:0] value);
        cfg_we    <= 1'b1;
        cfg_wdata <= value;
        @(posedge clk);
        sb.set_threshold(value);
        cfg_we    <= 1'b0;
    endtask

    function automatic logic [15:0] pick_voltage();
        case ($urandom_range(0, 5))
            0: return 16'($urandom);
            1:
            begin
                case ($urandom_range(0, 7))
                    0: return 16'd99;
                    1: return 16'd100;
                    2: return 16'd549;
                    3: return 16'd550;
                    4: return 16'd679;
                    5: return 16'd680;
                    6: return 16'd849;
                    default: return 16'd850;
                endcase
            end
            2: return sb.threshold;
            default: return 16'($urandom_range(0, 900));
        endcase
    endfunction

    function automatic logic [15:0] below_threshold();
        if (sb.threshold == 16'd0)
            return 16'd0;
        return 16'($urandom_range(0, sb.threshold - 1));
    endfunction

    // Mostly words that move the charger on from its current state; the rest noise.
    function automatic item_t next_item();
        item_t it;
        it = '0;
        it.cmd = KIND_POLL;
        it.link_ok = 1'b1;
        it.link_offline = 1'($urandom_range(0, 1));
        it.batt_dv = pick_voltage();
        it.charger_full = ($urandom_range(0, 3) == 0);
        it.write_ok = 1'($urandom_range(0, 1));
        if ($urandom_range(0, 99) < 15)
        begin
            it.cmd = 1'($urandom_range(0, 1));
            it.link_ok = ($urandom_range(0, 3) != 0);
            it.charger_fault = ($urandom_range(0, 3) == 0);
            it.batt_dv = 16'($urandom);
            return it;
        end
        case (sb.state)
            ST_DET, ST_CFG:
            begin
                it.cmd = 1'($urandom_range(0, 1));
                it.write_ok = ($urandom_range(0, 4) != 0);
            end
            ST_CHG: it.charger_full = ($urandom_range(0, 2) == 0);
            ST_FIN, ST_FLT:
            begin
                if ($urandom_range(0, 1))
                    it.batt_dv = below_threshold();
            end
            default: ;
        endcase
        return it;
    endfunction

    // Main sequence: reset, directed walk through the states, random phases.
    initial
    begin
        logic [15:0] thr;
        int          mode;
        sb = new();
        src_idle_pct  = 0;
        snk_stall_pct = 0;
        rst_n         <= 1'b0;
        s_axis_tvalid <= 1'b0;
        s_axis_tdata  <= '0;
        s_axis_tuser  <= '0;
        cfg_we        <= 1'b0;
        cfg_wdata     <= '0;
        repeat (9) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Idle with no battery, an ignored outcome, voltages outside the table.
        poll(1'b1, 1'b0, 16'd0, 1'b0, 1'b0);
        poll(1'b1, 1'b0, 16'd99, 1'b0, 1'b0);
        outcome(1'b1);
        poll(1'b1, 1'b0, 16'hFFFF, 1'b0, 1'b0);
        poll(1'b1, 1'b0, 16'd850, 1'b0, 1'b0);
        // Full charge cycle on the lowest table row.
        poll(1'b1, 1'b0, 16'd100, 1'b0, 1'b0);
        poll(1'b1, 1'b0, 16'd100, 1'b0, 1'b0);
        outcome(1'b0);
        outcome(1'b1);
        poll(1'b1, 1'b0, 16'd100, 1'b0, 1'b0);
        outcome(1'b1);
        poll(1'b1, 1'b0, 16'd500, 1'b0, 1'b0);
        poll(1'b1, 1'b0, 16'd500, 1'b0, 1'b1);
        poll(1'b1, 1'b0, 16'd200, 1'b0, 1'b0);
        poll(1'b1, 1'b0, 16'd99, 1'b0, 1'b0);
        // Link failures: held state, then an offline bus forcing fault.
        poll(1'b1, 1'b0, 16'd849, 1'b0, 1'b0);
        poll(1'b0, 1'b0, 16'd849, 1'b0, 1'b0);
        poll(1'b0, 1'b1, 16'd849, 1'b0, 1'b0);
        poll(1'b1, 1'b0, 16'd500, 1'b0, 1'b0);
        poll(1'b1, 1'b0, 16'd0, 1'b0, 1'b0);
        // Charger fault while detected, then removal and an offline bus in idle.
        poll(1'b1, 1'b0, 16'd550, 1'b0, 1'b0);
        poll(1'b1, 1'b0, 16'd550, 1'b1, 1'b0);
        poll(1'b1, 1'b0, 16'd50, 1'b0, 1'b0);
        poll(1'b0, 1'b1, 16'd680, 1'b0, 1'b0);
        poll(1'b1, 1'b0, 16'd0, 1'b0, 1'b0);
        drain();

        // Random phases, each with a chosen threshold and idling pattern.
        for (int phase = 0; phase < 6; phase++)
        begin
            case (phase)
                1: thr = 16'd0;
                2: thr = 16'hFFFF;
                3: thr = 16'd550;
                4: thr = 16'($urandom_range(0, 900));
                5: thr = 16'd100;
                default: thr = INSERT_THRESHOLD_RESET;
            endcase
            if (phase != 0)
                write_threshold(thr);
            mode = phase % 4;
            src_idle_pct  = (mode == 1) ? 65 : (mode == 3) ? 11 : 0;
            snk_stall_pct = (mode == 2) ? 65 : (mode == 3) ? 11 : 0;
            repeat (245) send_word(next_item());
            drain();
        end

        repeat (8) @(posedge clk);
        $display("Checked %0d result words for %0d input words over six threshold settings.",
                 sb.words_out, sb.words_in);
        $display("Charger states reached (bit per state, fault highest): %b", sb.states_seen);
        if (sb.mismatches == 0)
            $display("No mismatches found");
        else
            $display("Mismatches found");
        $finish;
    end

endmodule
